// File: sv/sterilizer_cycle_door_interlock_unit_assert.svh
// Assertion macros for the sterilizer door interlock unit.
// Used by the top level only; no other dependencies.
`ifndef STERILIZER_CYCLE_DOOR_INTERLOCK_UNIT_ASSERT_SVH
`define STERILIZER_CYCLE_DOOR_INTERLOCK_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SCDI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SCDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// File: sv/scdi_pkg.sv
// Shared constants for the sterilizer cycle door interlock unit.
// No dependencies; used by the top level by scoped names.
package scdi_pkg;

   localparam int TimerWidth = 16;
   localparam int CfgWidth   = 16;
   localparam int CodeWidth  = 10;
   localparam int CmpWidth   = (TimerWidth > CfgWidth) ? TimerWidth : CfgWidth;

   // Cycle phases.
   localparam logic [1:0] PhaseIdle     = 2'd0;
   localparam logic [1:0] PhaseSterile  = 2'd1;
   localparam logic [1:0] PhaseComplete = 2'd2;

   // Door unlock outcomes.
   localparam logic [2:0] UnlockNone     = 3'd0;
   localparam logic [2:0] UnlockDone     = 3'd1;
   localparam logic [2:0] UnlockEmerg    = 3'd2;
   localparam logic [2:0] BlockSterile   = 3'd3;
   localparam logic [2:0] BlockTemp      = 3'd4;
   localparam logic [2:0] BlockPress     = 3'd5;

   // Configuration register indexes.
   localparam logic [2:0] RegCycleTicks    = 3'd0;
   localparam logic [2:0] RegBlindTicks    = 3'd1;
   localparam logic [2:0] RegDebounceTicks = 3'd2;
   localparam logic [2:0] RegTempLimit     = 3'd3;
   localparam logic [2:0] RegPressLimit    = 3'd4;

   // Configuration reset values.
   localparam logic [CfgWidth-1:0]  CycleTicksReset    = 16'd6000;
   localparam logic [CfgWidth-1:0]  BlindTicksReset    = 16'd3000;
   localparam logic [CfgWidth-1:0]  DebounceTicksReset = 16'd200;
   localparam logic [CodeWidth-1:0] TempLimitReset     = 10'd613;
   localparam logic [CodeWidth-1:0] PressLimitReset    = 10'd537;

   localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};

endpackage

// File: sv/sterilizer_cycle_door_interlock_unit.sv
// Sterilizer cycle door interlock: an accepted tick's result is registered and ready in the next
// cycle; one tick per cycle while not stalled, set by the single pass of compares and counter updates.
// The result register is a one-entry output stage; a new tick is taken while it is empty
// or its result leaves in the same cycle.
// Synchronous active-high reset returns the state to idle, unlocked, timers at zero, and the
// configuration registers to their defaults. Depends on scdi_pkg and the assertion macros.
`include "sterilizer_cycle_door_interlock_unit_assert.svh"

module sterilizer_cycle_door_interlock_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Tick input channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_estop_pressed,
   input  logic                           req_door_request,
   input  logic [scdi_pkg::CodeWidth-1:0] req_temp_sample,
   input  logic [scdi_pkg::CodeWidth-1:0] req_press_sample,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_phase,
   output logic                           rsp_door_locked,
   output logic                           rsp_error_active,
   output logic                           rsp_idle_lamp,
   output logic                           rsp_running_lamp,
   output logic [2:0]                     rsp_unlock_result,
   output logic                           rsp_blind,
   // Configuration write port.
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [scdi_pkg::CfgWidth-1:0]  csr_wdata
);

   localparam int TW = scdi_pkg::TimerWidth;
   localparam int CW = scdi_pkg::CmpWidth;

   // Configuration registers.
   logic [scdi_pkg::CfgWidth-1:0]  cycle_ticks_ff, blind_ticks_ff, debounce_ticks_ff;
   logic [scdi_pkg::CodeWidth-1:0] temp_limit_ff, press_limit_ff;

   // Controller state and its next values.
   logic [1:0]                     phase_ff, phase_in;
   logic                           lock_ff, lock_in;
   logic                           error_ff, error_in;
   logic                           estop_prev_ff, estop_prev_in;
   logic [TW-1:0]                  phase_elapsed_ff, phase_elapsed_in;
   logic [TW-1:0]                  since_press_ff, since_press_in;
   logic [scdi_pkg::CfgWidth-1:0]  blind_left_ff, blind_left_in;
   logic [scdi_pkg::CodeWidth-1:0] temp_code_ff, temp_code_in;
   logic [scdi_pkg::CodeWidth-1:0] press_code_ff, press_code_in;
   logic [2:0]                     result_in;

   // Output stage.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_phase_ff;
   logic       rsp_door_locked_ff, rsp_error_active_ff, rsp_idle_lamp_ff;
   logic       rsp_running_lamp_ff, rsp_blind_ff;
   logic [2:0] rsp_unlock_result_ff;

   logic req_accept;

   // A tick is taken whenever the output stage is empty or drains this cycle.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ticks_ff    <= scdi_pkg::CycleTicksReset;
         blind_ticks_ff    <= scdi_pkg::BlindTicksReset;
         debounce_ticks_ff <= scdi_pkg::DebounceTicksReset;
         temp_limit_ff     <= scdi_pkg::TempLimitReset;
         press_limit_ff    <= scdi_pkg::PressLimitReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            scdi_pkg::RegCycleTicks:    cycle_ticks_ff    <= csr_wdata;
            scdi_pkg::RegBlindTicks:    blind_ticks_ff    <= csr_wdata;
            scdi_pkg::RegDebounceTicks: debounce_ticks_ff <= csr_wdata;
            scdi_pkg::RegTempLimit:     temp_limit_ff     <= csr_wdata[scdi_pkg::CodeWidth-1:0];
            scdi_pkg::RegPressLimit:    press_limit_ff    <= csr_wdata[scdi_pkg::CodeWidth-1:0];
            default: ;
         endcase
      end
   end

   // One tick of the controller. The statements follow the order in which the
   // events take effect: the emergency stop first, then the timed phase change,
   // then the door button, then sensor sampling and the timer advance.
   always_comb begin
      logic started;
      logic debounced;
      phase_in         = phase_ff;
      lock_in          = lock_ff;
      error_in         = error_ff;
      estop_prev_in    = estop_prev_ff;
      phase_elapsed_in = phase_elapsed_ff;
      since_press_in   = since_press_ff;
      blind_left_in    = blind_left_ff;
      temp_code_in     = temp_code_ff;
      press_code_in    = press_code_ff;
      result_in        = scdi_pkg::UnlockNone;
      started          = 1'b0;
      debounced        = CW'(since_press_ff) > CW'(debounce_ticks_ff);

      if (blind_left_ff != '0) begin
         // Blind window after a start: inputs are ignored entirely.
         blind_left_in = blind_left_ff - 1'b1;
      end else begin
         // A debounced rising press toggles the latched error.
         if (req_estop_pressed && !estop_prev_ff && debounced) begin
            if (!error_ff) begin
               error_in  = 1'b1;
               phase_in  = scdi_pkg::PhaseComplete;
               result_in = scdi_pkg::UnlockEmerg;
            end else begin
               error_in = 1'b0;
               phase_in = scdi_pkg::PhaseIdle;
            end
            lock_in        = 1'b0;
            since_press_in = '0;
            debounced      = 1'b0;
         end
         estop_prev_in = req_estop_pressed;

         // Timed phase change, held off while the error is latched.
         if (!error_in && CW'(phase_elapsed_ff) >= CW'(cycle_ticks_ff)) begin
            phase_elapsed_in = '0;
            case (phase_in)
               scdi_pkg::PhaseIdle: begin
                  phase_in      = scdi_pkg::PhaseSterile;
                  lock_in       = 1'b1;
                  blind_left_in = blind_ticks_ff;
                  started       = 1'b1;
               end
               scdi_pkg::PhaseSterile: begin
                  phase_in = scdi_pkg::PhaseComplete;
                  lock_in  = 1'b0;
               end
               default: begin
                  phase_in = scdi_pkg::PhaseIdle;
                  lock_in  = 1'b0;
               end
            endcase
         end

         // The start tick skips the door button and the sensor sampling.
         if (!started) begin
            if (req_door_request && debounced) begin
               if (req_estop_pressed) begin
                  lock_in   = 1'b0;
                  result_in = scdi_pkg::UnlockEmerg;
               end else if (phase_in == scdi_pkg::PhaseSterile) begin
                  result_in = scdi_pkg::BlockSterile;
               end else if (temp_code_ff > temp_limit_ff) begin
                  result_in = scdi_pkg::BlockTemp;
               end else if (press_code_ff > press_limit_ff) begin
                  result_in = scdi_pkg::BlockPress;
               end else begin
                  lock_in   = 1'b0;
                  result_in = scdi_pkg::UnlockDone;
               end
               since_press_in = '0;
            end
            temp_code_in  = req_temp_sample;
            press_code_in = req_press_sample;
         end
      end

      // Both timers saturate at their all-ones value.
      if (phase_elapsed_in != scdi_pkg::TimerMax) begin
         phase_elapsed_in = phase_elapsed_in + 1'b1;
      end
      if (since_press_in != scdi_pkg::TimerMax) begin
         since_press_in = since_press_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= scdi_pkg::PhaseIdle;
         lock_ff          <= 1'b0;
         error_ff         <= 1'b0;
         estop_prev_ff    <= 1'b0;
         phase_elapsed_ff <= '0;
         since_press_ff   <= '0;
         blind_left_ff    <= '0;
         temp_code_ff     <= '0;
         press_code_ff    <= '0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         lock_ff          <= lock_in;
         error_ff         <= error_in;
         estop_prev_ff    <= estop_prev_in;
         phase_elapsed_ff <= phase_elapsed_in;
         since_press_ff   <= since_press_in;
         blind_left_ff    <= blind_left_in;
         temp_code_ff     <= temp_code_in;
         press_code_ff    <= press_code_in;
      end
   end

   // The output stage holds a result until its transfer completes.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_phase_ff         <= phase_in;
         rsp_door_locked_ff   <= lock_in;
         rsp_error_active_ff  <= error_in;
         rsp_idle_lamp_ff     <= !error_in && (phase_in == scdi_pkg::PhaseIdle ||
                                               phase_in == scdi_pkg::PhaseComplete);
         rsp_running_lamp_ff  <= !error_in && (phase_in == scdi_pkg::PhaseSterile);
         rsp_unlock_result_ff <= result_in;
         rsp_blind_ff         <= blind_left_in != '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_door_locked   = rsp_door_locked_ff;
   assign rsp_error_active  = rsp_error_active_ff;
   assign rsp_idle_lamp     = rsp_idle_lamp_ff;
   assign rsp_running_lamp  = rsp_running_lamp_ff;
   assign rsp_unlock_result = rsp_unlock_result_ff;
   assign rsp_blind         = rsp_blind_ff;

   // A result waiting on a stalled consumer must block new ticks.
   `SCDI_ASSERT_NOW(a_stall_holds_input, clock, reset, rsp_valid_ff && rsp_stall, req_stall)
   // The blind window only exists inside a locked, error-free sterilizing phase.
   `SCDI_ASSERT_NOW(a_blind_sterile, clock, reset, blind_left_ff != '0,
      phase_ff == scdi_pkg::PhaseSterile && lock_ff && !error_ff)
   // A latched error parks the cycle in complete with the door released.
   `SCDI_ASSERT_NOW(a_error_parked, clock, reset, error_ff,
      phase_ff == scdi_pkg::PhaseComplete && !lock_ff)
   // An accepted tick always leaves a result in the output stage.
   `SCDI_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid_ff)

endmodule
